### rtl/generational_handle_table_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the generational handle table
// Shared property forms, clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef GENERATIONAL_HANDLE_TABLE_TOP_ASSERT_SVH
`define GENERATIONAL_HANDLE_TABLE_TOP_ASSERT_SVH

// Same-cycle implication.
`define GHT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define GHT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/ght_pkg.sv
// ----------------------------------------------------------------------------
// ght_pkg
// Types, codes and helper functions shared by the handle table modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ght_pkg;

    localparam int CAPACITY_DEF      = 64;
    localparam int KIND_MAX_DEF      = 15;
    localparam int DUP_RIGHT_BIT_DEF = 0;

    localparam int IN_TDATA_W  = 208;
    localparam int OUT_TDATA_W = 152;
    localparam int OPEN_W      = 16;

    typedef enum logic [2:0] {
        CMD_INSERT    = 3'd0,
        CMD_RESOLVE   = 3'd1,
        CMD_DUPLICATE = 3'd2,
        CMD_CLOSE     = 3'd3,
        CMD_CLOSE_ALL = 3'd4
    } cmd_t;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_INVALID    = 3'd1,
        ST_BAD_HANDLE = 3'd2,
        ST_WRONG_TYPE = 3'd3,
        ST_DENIED     = 3'd4,
        ST_NO_SPACE   = 3'd5,
        ST_BAD_STATE  = 3'd6
    } status_t;

    typedef enum logic [2:0] {
        OP_INSERT    = 3'd0,
        OP_RESOLVE   = 3'd1,
        OP_DUP       = 3'd2,
        OP_CLOSE     = 3'd3,
        OP_CLOSE_ALL = 3'd4,
        OP_REJECT    = 3'd5
    } op_t;

    // One classified transaction as it travels from the front to the back.
    typedef struct packed {
        op_t         op;
        status_t     status;
        logic        handle_ok;
        logic [15:0] slot;
        logic [23:0] ctr;
        logic [63:0] object_ref;
        logic [7:0]  kind;
        logic [63:0] rights;
        logic        ret_flag;
        logic        rel_flag;
        logic        rights_ok;
    } ght_item_t;

    typedef struct packed {
        logic [63:0] object_ref;
        logic [7:0]  kind;
        logic [63:0] rights;
        logic        ret_flag;
        logic        rel_flag;
        logic [23:0] ctr;
    } ght_entry_t;

    typedef struct packed {
        status_t     status;
        logic [63:0] handle_out;
        logic [63:0] object_out;
        logic        retain_req;
        logic        release_req;
        logic        last;
    } ght_result_t;

    function automatic logic [23:0] fold_tag(input logic [63:0] id);
        logic [23:0] t;
        t = id[23:0] ^ id[47:24] ^ {8'h00, id[63:48]};
        if (id == 64'd0)
            return 24'd0;
        else if (t == 24'd0)
            return 24'd1;
        else
            return t;
    endfunction

    // Counter advance on close; a wrap to zero restarts at one.
    function automatic logic [23:0] next_ctr(input logic [23:0] c);
        logic [23:0] n;
        n = c + 24'd1;
        return (n == 24'd0) ? 24'd1 : n;
    endfunction

endpackage

### rtl/generational_handle_table_top.sv
// ----------------------------------------------------------------------------
// generational_handle_table_top
// Generational capability handle table with stream ports and a register port.
// ----------------------------------------------------------------------------
// Input transactions arrive on the s_axis channel (command in tuser, the
// operands in tdata); results leave on the m_axis channel, with tlast on the
// last result of each input transaction. Close-all gives one result per
// occupied slot, or a single result when the table is empty.
// Registers are written over the APB-style port: the owner ID at address 0,
// valid_rights at address 8. Writing the owner ID frees every slot and
// restarts every reuse counter at one; write it only while the block is idle.
// A rejected transaction goes straight to the output register. A resolve, insert
// or close reads its slot, checks it and, for an insert or close, writes it; a
// duplicate does so for the source slot and then for a free slot. A close-all
// scans the slots in order, skipping free ones, and gives a result per occupied
// slot. The sequencer takes a new transaction once the last result is loaded; the
// rate is set by the single-port slot memory, read and then rewritten per command.
// A two-entry queue sits between the classifying front end and the sequencer,
// so two transactions can be taken while the back end is busy. If m_axis
// stalls, the result is held in the output register, the sequencer waits, the
// queue fills and s_axis_tready drops. Reset empties the table, clears the
// queue and output, clears the owner ID and sets valid_rights to all ones.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module generational_handle_table_top
    import ght_pkg::*;
#(
    parameter int CAPACITY      = CAPACITY_DEF,
    parameter int KIND_MAX      = KIND_MAX_DEF,
    parameter int DUP_RIGHT_BIT = DUP_RIGHT_BIT_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // handle[63:0], object_ref[127:64], kind[135:128], rights[199:136],
    // has_retain[200], has_release[201], zero fill above
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // command[2:0]
    input  logic [2:0]             s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // handle_out[63:0], object_out[127:64], retain_request[128],
    // release_request[129], open_handles[145:130], zero fill above
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    // status[2:0]
    output logic [2:0]             m_axis_tuser,
    output logic                   m_axis_tlast,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [3:0]             paddr,
    input  logic [63:0]            pwdata,
    output logic [63:0]            prdata,
    output logic                   pready
);

    logic [63:0]       owner_reg;
    logic [63:0]       vrights_reg;
    logic [23:0]       tag_reg;
    logic              cfg_wr;
    logic              clear;
    logic              push;
    logic              pop;
    logic              q_full;
    logic              q_empty;
    ght_item_t         push_item;
    ght_item_t         q_head;
    ght_result_t       out_res;
    logic [OPEN_W-1:0] out_open;

    // Register port: paddr[3] selects the register, one write per access.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign clear  = cfg_wr && !paddr[3];
    assign prdata = paddr[3] ? vrights_reg : owner_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            owner_reg   <= 64'd0;
            vrights_reg <= '1;
            tag_reg     <= 24'd0;
        end
        else if (cfg_wr)
        begin
            if (paddr[3])
                vrights_reg <= pwdata;
            else
            begin
                owner_reg <= pwdata;
                tag_reg   <= fold_tag(pwdata);
            end
        end
    end

    ght_front #(
        .CAPACITY (CAPACITY),
        .KIND_MAX (KIND_MAX)
    ) u_front (
        .in_valid     (s_axis_tvalid),
        .in_ready     (s_axis_tready),
        .command      (s_axis_tuser),
        .handle       (s_axis_tdata[63:0]),
        .object_ref   (s_axis_tdata[127:64]),
        .kind         (s_axis_tdata[135:128]),
        .rights       (s_axis_tdata[199:136]),
        .has_retain   (s_axis_tdata[200]),
        .has_release  (s_axis_tdata[201]),
        .tag          (tag_reg),
        .valid_rights (vrights_reg),
        .q_full       (q_full),
        .push         (push),
        .item         (push_item)
    );

    ght_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head      (q_head),
        .empty     (q_empty),
        .full      (q_full)
    );

    ght_back #(
        .CAPACITY      (CAPACITY),
        .DUP_RIGHT_BIT (DUP_RIGHT_BIT)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .clear     (clear),
        .tag       (tag_reg),
        .q_head    (q_head),
        .q_empty   (q_empty),
        .pop       (pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_res   (out_res),
        .out_open  (out_open)
    );

    // Result packing onto the master side.
    assign m_axis_tuser = out_res.status;
    assign m_axis_tlast = out_res.last;
    assign m_axis_tdata = {6'd0, out_open, out_res.release_req, out_res.retain_req,
                           out_res.object_out, out_res.handle_out};

endmodule

### rtl/ght_front.sv
// ----------------------------------------------------------------------------
// ght_front
// Accepts input transactions and classifies them for the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ght_front
    import ght_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF,
    parameter int KIND_MAX = KIND_MAX_DEF
)
(
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  command,
    input  logic [63:0] handle,
    input  logic [63:0] object_ref,
    input  logic [7:0]  kind,
    input  logic [63:0] rights,
    input  logic        has_retain,
    input  logic        has_release,
    input  logic [23:0] tag,
    input  logic [63:0] valid_rights,
    input  logic        q_full,
    output logic        push,
    output ght_item_t   item
);

    logic rights_ok;
    logic in_range;

    assign rights_ok = (rights & ~valid_rights) == 64'd0;
    assign in_range  = (handle[15:0] != 16'd0) && (handle[15:0] <= 16'(CAPACITY));
    assign in_ready  = !q_full;
    assign push      = in_valid && !q_full;

    always_comb
    begin
        item            = '0;
        item.handle_ok  = in_range && (handle[63:40] == tag);
        item.slot       = handle[15:0];
        item.ctr        = handle[39:16];
        item.object_ref = object_ref;
        item.kind       = kind;
        item.rights     = rights;
        item.ret_flag   = has_retain;
        item.rel_flag   = has_release;
        item.rights_ok  = rights_ok;
        item.status     = ST_INVALID;
        item.op         = OP_REJECT;
        case (command)
            CMD_INSERT:
            begin
                if (tag != 24'd0 && object_ref != 64'd0 && kind != 8'd0
                    && kind <= 8'(KIND_MAX) && rights_ok)
                    item.op = OP_INSERT;
            end
            CMD_RESOLVE:
            begin
                if (kind != 8'd0 && rights_ok)
                    item.op = OP_RESOLVE;
            end
            CMD_DUPLICATE: item.op = OP_DUP;
            CMD_CLOSE:     item.op = OP_CLOSE;
            CMD_CLOSE_ALL: item.op = OP_CLOSE_ALL;
            default:       item.op = OP_REJECT;
        endcase
    end

endmodule

### rtl/ght_queue.sv
// ----------------------------------------------------------------------------
// ght_queue
// Two-entry queue of classified transactions between front and back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ght_queue
    import ght_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  ght_item_t push_item,
    input  logic      pop,
    output ght_item_t head,
    output logic      empty,
    output logic      full
);

    ght_item_t   entry_reg [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  count_reg;

    assign empty = (count_reg == 2'd0);
    assign full  = (count_reg == 2'd2);
    assign head  = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            if (push && !pop)
                count_reg <= count_reg + 2'd1;
            else if (pop && !push)
                count_reg <= count_reg - 2'd1;
        end
    end

endmodule

### rtl/ght_back.sv
// ----------------------------------------------------------------------------
// ght_back
// Slot memory, occupancy and the sequencer that carries out each command.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "generational_handle_table_top_assert.svh"

module ght_back
    import ght_pkg::*;
#(
    parameter int CAPACITY      = CAPACITY_DEF,
    parameter int DUP_RIGHT_BIT = DUP_RIGHT_BIT_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              clear,
    input  logic [23:0]       tag,
    input  ght_item_t         q_head,
    input  logic              q_empty,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_ready,
    output ght_result_t       out_res,
    output logic [OPEN_W-1:0] out_open
);

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_RD   = 7'b0000010,
        S_CHK  = 7'b0000100,
        S_RD2  = 7'b0001000,
        S_CHK2 = 7'b0010000,
        S_SCAN = 7'b0100000,
        S_EMIT = 7'b1000000
    } state_t;

    ght_entry_t mem [CAPACITY];

    state_t            state_reg, state_next;
    ght_item_t         item_reg, item_next;
    ght_result_t       res_reg, res_next;
    ght_entry_t        src_reg, src_next;
    ght_entry_t        rd_data_reg;
    ght_entry_t        wr_data;
    logic [IDX_W-1:0]  rd_addr, rd_addr_reg;
    logic [IDX_W-1:0]  scan_reg, scan_next;
    logic [IDX_W-1:0]  free_idx, free_idx_reg;
    logic              any_free, any_free_reg;
    logic [CAPACITY-1:0] occ_reg;
    logic [CAPACITY-1:0] ctrv_reg;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              wr_en;
    logic              wr_occ;
    logic              load;
    logic              out_valid_reg;
    ght_result_t       out_res_reg;
    logic [OPEN_W-1:0] out_open_reg;
    logic [15:0]       slot_m1;
    logic [IDX_W-1:0]  idx;
    logic [23:0]       eff_ctr;
    logic              match;

    assign slot_m1 = item_reg.slot - 16'd1;
    assign idx     = slot_m1[IDX_W-1:0];
    assign eff_ctr = ctrv_reg[rd_addr_reg] ? rd_data_reg.ctr : 24'd1;
    assign match   = item_reg.handle_ok && occ_reg[rd_addr_reg]
                     && (eff_ctr == item_reg.ctr);

    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;
    assign out_open  = out_open_reg;

    // Lowest free slot, registered.
    always_comb
    begin
        free_idx = '0;
        any_free = 1'b0;
        for (int i = CAPACITY - 1; i >= 0; i--)
        begin
            if (!occ_reg[i])
            begin
                free_idx = IDX_W'(i);
                any_free = 1'b1;
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        item_next  = item_reg;
        res_next   = res_reg;
        src_next   = src_reg;
        scan_next  = scan_reg;
        count_next = count_reg;
        rd_addr    = rd_addr_reg;
        wr_en      = 1'b0;
        wr_occ     = 1'b0;
        wr_data    = rd_data_reg;
        pop        = 1'b0;
        load       = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    pop       = 1'b1;
                    item_next = q_head;
                    res_next  = '0;
                    res_next.last = 1'b1;
                    case (q_head.op)
                        OP_REJECT:
                        begin
                            res_next.status = q_head.status;
                            state_next      = S_EMIT;
                        end
                        OP_CLOSE_ALL:
                        begin
                            scan_next = '0;
                            if (count_reg == '0)
                                state_next = S_EMIT;
                            else
                                state_next = S_SCAN;
                        end
                        default: state_next = S_RD;
                    endcase
                end
            end
            S_RD:
            begin
                rd_addr    = (item_reg.op == OP_INSERT) ? free_idx_reg : idx;
                state_next = S_CHK;
            end
            S_SCAN:
            begin
                if (occ_reg[scan_reg])
                begin
                    rd_addr    = scan_reg;
                    state_next = S_CHK;
                end
                else
                    scan_next = scan_reg + IDX_W'(1);
            end
            S_CHK:
            begin
                res_next      = '0;
                res_next.last = 1'b1;
                state_next    = S_EMIT;
                case (item_reg.op)
                    OP_INSERT:
                    begin
                        if (!any_free_reg)
                            res_next.status = ST_NO_SPACE;
                        else
                        begin
                            wr_en   = 1'b1;
                            wr_occ  = 1'b1;
                            wr_data = '{item_reg.object_ref, item_reg.kind, item_reg.rights,
                                        item_reg.ret_flag, item_reg.rel_flag, eff_ctr};
                            count_next = count_reg + CNT_W'(1);
                            res_next.handle_out = {tag, eff_ctr,
                                                   16'(rd_addr_reg) + 16'd1};
                        end
                    end
                    OP_RESOLVE:
                    begin
                        if (!match)
                            res_next.status = ST_BAD_HANDLE;
                        else if (rd_data_reg.kind != item_reg.kind)
                            res_next.status = ST_WRONG_TYPE;
                        else if ((rd_data_reg.rights & item_reg.rights) != item_reg.rights)
                            res_next.status = ST_DENIED;
                        else
                            res_next.object_out = rd_data_reg.object_ref;
                    end
                    OP_CLOSE, OP_CLOSE_ALL:
                    begin
                        if (item_reg.op == OP_CLOSE && !match)
                            res_next.status = ST_BAD_HANDLE;
                        else
                        begin
                            wr_en       = 1'b1;
                            wr_data.ctr = next_ctr(eff_ctr);
                            count_next  = count_reg - CNT_W'(1);
                            res_next.object_out  = rd_data_reg.object_ref;
                            res_next.release_req = rd_data_reg.rel_flag;
                            res_next.last = (item_reg.op == OP_CLOSE)
                                            || (count_reg == CNT_W'(1));
                        end
                    end
                    OP_DUP:
                    begin
                        if (!match)
                            res_next.status = ST_BAD_HANDLE;
                        else if (!rd_data_reg.rights[DUP_RIGHT_BIT]
                                 || (item_reg.rights & ~rd_data_reg.rights) != 64'd0)
                            res_next.status = ST_DENIED;
                        else if (rd_data_reg.rel_flag && !rd_data_reg.ret_flag)
                            res_next.status = ST_BAD_STATE;
                        else
                        begin
                            res_next.object_out = rd_data_reg.object_ref;
                            res_next.retain_req = rd_data_reg.ret_flag;
                            if (!item_reg.rights_ok || !any_free_reg)
                            begin
                                res_next.status = item_reg.rights_ok ? ST_NO_SPACE
                                                                     : ST_INVALID;
                                res_next.release_req = rd_data_reg.rel_flag;
                            end
                            else
                            begin
                                src_next   = rd_data_reg;
                                state_next = S_RD2;
                            end
                        end
                    end
                    default: res_next.status = ST_INVALID;
                endcase
            end
            S_RD2:
            begin
                rd_addr    = free_idx_reg;
                state_next = S_CHK2;
            end
            S_CHK2:
            begin
                wr_en      = 1'b1;
                wr_occ     = 1'b1;
                wr_data    = '{src_reg.object_ref, src_reg.kind, item_reg.rights,
                               src_reg.ret_flag, src_reg.rel_flag, eff_ctr};
                count_next = count_reg + CNT_W'(1);
                res_next.handle_out = {tag, eff_ctr, 16'(rd_addr_reg) + 16'd1};
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    load = 1'b1;
                    if (item_reg.op == OP_CLOSE_ALL && !res_reg.last)
                    begin
                        scan_next  = scan_reg + IDX_W'(1);
                        state_next = S_SCAN;
                    end
                    else
                        state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[rd_addr_reg] <= wr_data;
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        res_reg      <= res_next;
        src_reg      <= src_next;
        scan_reg     <= scan_next;
        rd_addr_reg  <= rd_addr;
        free_idx_reg <= free_idx;
        if (load)
        begin
            out_res_reg  <= res_reg;
            out_open_reg <= OPEN_W'(count_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            occ_reg       <= '0;
            ctrv_reg      <= '0;
            count_reg     <= '0;
            any_free_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            any_free_reg <= any_free;
            if (clear)
            begin
                occ_reg   <= '0;
                ctrv_reg  <= '0;
                count_reg <= '0;
            end
            else if (wr_en)
            begin
                occ_reg[rd_addr_reg]  <= wr_occ;
                ctrv_reg[rd_addr_reg] <= 1'b1;
                count_reg             <= count_next;
            end
            if (load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    `GHT_ASSERT_NOW(a_count_matches, 1'b1, count_reg == CNT_W'($countones(occ_reg)), "open count differs from occupancy")
    `GHT_ASSERT_NOW(a_occ_has_ctr, 1'b1, (occ_reg & ~ctrv_reg) == '0, "occupied slot without written counter")
    `GHT_ASSERT_NOW(a_free_is_free, (state_reg == S_RD2) || (state_reg == S_RD && item_reg.op == OP_INSERT && any_free_reg), !occ_reg[free_idx_reg], "chosen free slot is occupied")
    `GHT_ASSERT_NEXT(a_load_shows, load, out_valid_reg && out_res_reg == $past(res_reg), "loaded result not presented")

endmodule

### verif/generational_handle_table_top_tb.sv
// ----------------------------------------------------------------------------
// generational_handle_table_top_tb
// Self-checking bench for the generational capability handle table.
// ----------------------------------------------------------------------------
// Commands go in on the s_axis channel and results come back on m_axis. A
// predictor inside the bench keeps its own copy of the slot table and works
// out every result of every accepted command. A monitor compares each result
// transaction with the oldest prediction. The run steps through several
// owner identities and rights masks, written over the register port only
// while the table is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module generational_handle_table_top_tb;
    import ght_pkg::*;

    localparam int NSLOT = CAPACITY_DEF;

    // One command as the bench sees it.
    typedef struct {
        cmd_t        cmd;
        logic [63:0] handle;
        logic [63:0] obj;
        logic [7:0]  kind;
        logic [63:0] rights;
        logic        ret;
        logic        rel;
    } command_t;

    // One predicted result transaction.
    typedef struct {
        status_t     status;
        logic [63:0] handle_out;
        logic [63:0] object_out;
        logic        retain_req;
        logic        release_req;
        logic [15:0] open_cnt;
        logic        last;
    } outcome_t;

    // Register addresses, one 64-bit register every 8 bytes.
    localparam logic [3:0] ADDR_OWNER  = 4'd0;
    localparam logic [3:0] ADDR_RIGHTS = 4'd8;

    logic                   clk;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic [2:0]             s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic [2:0]             m_axis_tuser;
    logic                   m_axis_tlast;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [3:0]             paddr;
    logic [63:0]            pwdata;
    logic [63:0]            prdata;
    logic                   pready;

    generational_handle_table_top uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    // ------------------------------------------------------------------
    // Predictor state: a mirror of the slot table and the registers.
    // ------------------------------------------------------------------
    logic [63:0] tbl_object  [NSLOT];
    logic [7:0]  tbl_kind    [NSLOT];
    logic [63:0] tbl_rights  [NSLOT];
    logic [23:0] tbl_counter [NSLOT];
    logic        tbl_retain  [NSLOT];
    logic        tbl_release [NSLOT];
    int unsigned tbl_open;
    logic [23:0] mirror_tag;
    logic [63:0] rights_mask;

    // Handles that insert and duplicate gave out, used to build good
    // (and, after close, stale) handles for later commands.
    logic [63:0] issued_handles[$];

    outcome_t    expected_results[$];
    command_t    pending_commands[$];

    int          mismatch_count;
    int          result_count;
    int          command_count;
    bit          idle_off;       // no random idling in the last part
    int          hold_left;      // cycles left in a long receiver hold-off

    function automatic logic [23:0] owner_fold(input logic [63:0] id);
        logic [23:0] t;
        t = id[23:0] ^ id[47:24] ^ {8'h00, id[63:48]};
        if (id == 64'd0)
            return 24'd0;
        return (t == 24'd0) ? 24'd1 : t;
    endfunction

    function automatic logic [63:0] handle_of(input int idx);
        logic [47:0] gen;
        gen = {mirror_tag, tbl_counter[idx]};
        return {gen, 16'(idx + 1)};
    endfunction

    task automatic wipe_table();
        for (int i = 0; i < NSLOT; i++)
        begin
            tbl_object[i]  = '0;
            tbl_kind[i]    = '0;
            tbl_rights[i]  = '0;
            tbl_counter[i] = 24'd1;
            tbl_retain[i]  = 1'b0;
            tbl_release[i] = 1'b0;
        end
        tbl_open = 0;
        issued_handles.delete();
    endtask

    // Returns the slot index for a live handle of the current generation,
    // or -1 when the handle is refused.
    function automatic int lookup_slot(input logic [63:0] h);
        int idx;
        if (h[15:0] == 16'd0 || h[15:0] > 16'(NSLOT))
            return -1;
        idx = int'(h[15:0]) - 1;
        if (tbl_object[idx] == 64'd0)
            return -1;
        if (h[63:16] != {mirror_tag, tbl_counter[idx]})
            return -1;
        return idx;
    endfunction

    task automatic store_entry(input logic [63:0] obj, input logic [7:0] kind,
                               input logic [63:0] rights, input logic ret,
                               input logic rel, output status_t st,
                               output logic [63:0] h);
        h  = '0;
        st = ST_NO_SPACE;
        if (mirror_tag == 24'd0 || obj == 64'd0 || kind == 8'd0
            || kind > 8'(KIND_MAX_DEF) || (rights & ~rights_mask) != 64'd0)
        begin
            st = ST_INVALID;
            return;
        end
        for (int i = 0; i < NSLOT; i++)
        begin
            if (tbl_object[i] == 64'd0)
            begin
                tbl_object[i]  = obj;
                tbl_kind[i]    = kind;
                tbl_rights[i]  = rights;
                tbl_retain[i]  = ret;
                tbl_release[i] = rel;
                tbl_open++;
                h  = handle_of(i);
                st = ST_OK;
                issued_handles.push_back(h);
                return;
            end
        end
    endtask

    task automatic free_slot(input int idx, output logic [63:0] obj,
                             output logic rel);
        obj = tbl_object[idx];
        rel = tbl_release[idx];
        tbl_object[idx]  = '0;
        tbl_kind[idx]    = '0;
        tbl_rights[idx]  = '0;
        tbl_retain[idx]  = 1'b0;
        tbl_release[idx] = 1'b0;
        tbl_counter[idx] = (tbl_counter[idx] == 24'hffffff) ? 24'd1
                                                              : tbl_counter[idx] + 24'd1;
        tbl_open--;
    endtask

    task automatic push_outcome(input status_t st, input logic [63:0] h,
                                input logic [63:0] obj, input logic ret,
                                input logic rel, input logic lst);
        outcome_t o;
        o.status      = st;
        o.handle_out  = h;
        o.object_out  = obj;
        o.retain_req  = ret;
        o.release_req = rel;
        o.open_cnt    = 16'(tbl_open);
        o.last        = lst;
        expected_results.push_back(o);
    endtask

    // Works out every result of one accepted command and updates the mirror.
    task automatic predict_command(input command_t c);
        int          idx;
        int          n;
        status_t     st;
        logic [63:0] h;
        logic [63:0] obj;
        logic        rel;
        n = 0;
        case (c.cmd)
            CMD_INSERT:
            begin
                store_entry(c.obj, c.kind, c.rights, c.ret, c.rel, st, h);
                push_outcome(st, h, '0, 1'b0, 1'b0, 1'b1);
            end
            CMD_RESOLVE:
            begin
                idx = lookup_slot(c.handle);
                if (c.kind == 8'd0 || (c.rights & ~rights_mask) != 64'd0)
                    push_outcome(ST_INVALID, '0, '0, 1'b0, 1'b0, 1'b1);
                else if (idx < 0)
                    push_outcome(ST_BAD_HANDLE, '0, '0, 1'b0, 1'b0, 1'b1);
                else if (tbl_kind[idx] != c.kind)
                    push_outcome(ST_WRONG_TYPE, '0, '0, 1'b0, 1'b0, 1'b1);
                else if ((tbl_rights[idx] & c.rights) != c.rights)
                    push_outcome(ST_DENIED, '0, '0, 1'b0, 1'b0, 1'b1);
                else
                    push_outcome(ST_OK, '0, tbl_object[idx], 1'b0, 1'b0, 1'b1);
            end
            CMD_DUPLICATE:
            begin
                idx = lookup_slot(c.handle);
                if (idx < 0)
                    push_outcome(ST_BAD_HANDLE, '0, '0, 1'b0, 1'b0, 1'b1);
                else if (!tbl_rights[idx][DUP_RIGHT_BIT_DEF]
                         || (c.rights & ~tbl_rights[idx]) != 64'd0)
                    push_outcome(ST_DENIED, '0, '0, 1'b0, 1'b0, 1'b1);
                else if (tbl_release[idx] && !tbl_retain[idx])
                    push_outcome(ST_BAD_STATE, '0, '0, 1'b0, 1'b0, 1'b1);
                else
                begin
                    obj = tbl_object[idx];
                    rel = tbl_release[idx];
                    store_entry(obj, tbl_kind[idx], c.rights, tbl_retain[idx], rel,
                                st, h);
                    // The source slot keeps its retain flag; read it back.
                    if (st == ST_OK)
                        push_outcome(ST_OK, h, obj, tbl_retain[idx], 1'b0, 1'b1);
                    else
                        push_outcome(st, '0, obj, tbl_retain[idx], rel, 1'b1);
                end
            end
            CMD_CLOSE:
            begin
                idx = lookup_slot(c.handle);
                if (idx < 0)
                    push_outcome(ST_BAD_HANDLE, '0, '0, 1'b0, 1'b0, 1'b1);
                else
                begin
                    free_slot(idx, obj, rel);
                    push_outcome(ST_OK, '0, obj, 1'b0, rel, 1'b1);
                end
            end
            CMD_CLOSE_ALL:
            begin
                for (int i = 0; i < NSLOT; i++)
                begin
                    if (tbl_object[i] != 64'd0)
                    begin
                        free_slot(i, obj, rel);
                        push_outcome(ST_OK, '0, obj, 1'b0, rel, 1'b0);
                        n++;
                    end
                end
                if (n == 0)
                    push_outcome(ST_OK, '0, '0, 1'b0, 1'b0, 1'b1);
                else
                    expected_results[$].last = 1'b1;
            end
            default:
                push_outcome(ST_INVALID, '0, '0, 1'b0, 1'b0, 1'b1);
        endcase
    endtask

    // ------------------------------------------------------------------
    // Driver: offers the head of pending_commands; inputs move on the
    // falling edge, acceptance is judged at the rising edge.
    // ------------------------------------------------------------------
    bit sent_pending;
    int src_gap;

    always @(posedge clk)
    begin
        sent_pending = s_axis_tvalid && s_axis_tready;
    end

    always @(negedge clk)
    begin
        command_t c;
        bit       can_idle;
        if (rst_n)
        begin
            // An offered transaction stays up until it is taken.
            can_idle = !s_axis_tvalid || sent_pending;
            if (sent_pending)
            begin
                c = pending_commands.pop_front();
                predict_command(c);
                command_count++;
            end
            if (src_gap > 0)
            begin
                src_gap--;
                s_axis_tvalid <= 1'b0;
            end
            else if (pending_commands.size() != 0 && can_idle
                     && !idle_off && $urandom_range(0, 9) == 0)
            begin
                src_gap = $urandom_range(1, 4) - 1;
                s_axis_tvalid <= 1'b0;
            end
            else if (pending_commands.size() != 0)
            begin
                c = pending_commands[0];
                s_axis_tvalid <= 1'b1;
                s_axis_tuser  <= c.cmd;
                s_axis_tdata  <= {6'd0, c.rel, c.ret, c.rights, c.kind, c.obj, c.handle};
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Monitor and receiver idling.
    // ------------------------------------------------------------------
    int sink_gap;

    always @(posedge clk)
    begin
        outcome_t e;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            result_count++;
            if (expected_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("ERROR: unexpected result transaction, tuser=%0d", m_axis_tuser);
            end
            else
            begin
                e = expected_results.pop_front();
                if (m_axis_tuser != e.status || m_axis_tdata[63:0] != e.handle_out
                    || m_axis_tdata[127:64] != e.object_out
                    || m_axis_tdata[128] != e.retain_req
                    || m_axis_tdata[129] != e.release_req
                    || m_axis_tdata[145:130] != e.open_cnt
                    || m_axis_tlast != e.last)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("ERROR: result %0d exp st=%0d h=%h o=%h ret=%b rel=%b open=%0d last=%b got st=%0d h=%h o=%h ret=%b rel=%b open=%0d last=%b",
                                 result_count, e.status, e.handle_out, e.object_out,
                                 e.retain_req, e.release_req, e.open_cnt, e.last,
                                 m_axis_tuser, m_axis_tdata[63:0], m_axis_tdata[127:64],
                                 m_axis_tdata[128], m_axis_tdata[129],
                                 m_axis_tdata[145:130], m_axis_tlast);
                end
            end
        end
    end

    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else if (sink_gap > 0)
        begin
            sink_gap--;
            m_axis_tready <= 1'b0;
        end
        else if (!idle_off && $urandom_range(0, 7) == 0)
        begin
            sink_gap = $urandom_range(1, 4) - 1;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= 1'b1;
    end

    // ------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------
    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    task automatic queue_command(input cmd_t cmd, input logic [63:0] h,
                                 input logic [63:0] obj, input logic [7:0] kind,
                                 input logic [63:0] rights, input logic ret,
                                 input logic rel);
        command_t c;
        c.cmd = cmd; c.handle = h; c.obj = obj; c.kind = kind;
        c.rights = rights; c.ret = ret; c.rel = rel;
        pending_commands.push_back(c);
    endtask

    // A handle from those given out so far, occasionally mangled.
    function automatic logic [63:0] pick_handle();
        logic [63:0] h;
        if (issued_handles.size() == 0 || $urandom_range(0, 9) == 0)
            return ($urandom_range(0, 1) != 0) ? rand64()
                                               : {rand64()} & 64'h0000_0000_0000_007f;
        h = issued_handles[$urandom_range(0, issued_handles.size() - 1)];
        if ($urandom_range(0, 15) == 0)
            h[$urandom_range(16, 63)] ^= 1'b1;
        return h;
    endfunction

    // Random command biased toward well-formed use of the table.
    task automatic queue_random_command();
        int          sel;
        logic [7:0]  kind;
        logic [63:0] rights;
        sel    = $urandom_range(0, 99);
        kind   = ($urandom_range(0, 9) == 0) ? 8'($urandom()) : 8'($urandom_range(1, 4));
        rights = ($urandom_range(0, 3) == 0) ? rand64() : 64'($urandom_range(0, 15));
        if (sel < 35)
            queue_command(CMD_INSERT, rand64(),
                          ($urandom_range(0, 19) == 0) ? 64'd0 : rand64(),
                          kind, rights, 1'($urandom()), 1'($urandom()));
        else if (sel < 55)
            queue_command(CMD_RESOLVE, pick_handle(), rand64(), kind,
                          64'($urandom_range(0, 3)), 1'($urandom()), 1'($urandom()));
        else if (sel < 72)
            queue_command(CMD_DUPLICATE, pick_handle(), rand64(), kind,
                          64'($urandom_range(0, 7)), 1'($urandom()), 1'($urandom()));
        else if (sel < 93)
            queue_command(CMD_CLOSE, pick_handle(), rand64(), kind, rights,
                          1'($urandom()), 1'($urandom()));
        else if (sel < 97)
            queue_command(CMD_CLOSE_ALL, rand64(), rand64(), kind, rights,
                          1'($urandom()), 1'($urandom()));
        else
            queue_command(cmd_t'($urandom_range(5, 7)), rand64(), rand64(), kind,
                          rights, 1'($urandom()), 1'($urandom()));
    endtask

    // Register write: setup cycle then access cycle, only while idle.
    task automatic write_register(input logic [3:0] addr, input logic [63:0] value);
        @(negedge clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        if (addr == ADDR_OWNER)
        begin
            mirror_tag = owner_fold(value);
            wipe_table();
        end
        else
            rights_mask = value;
    endtask

    // Waits until every queued command is taken and every result is back.
    task automatic wait_quiet();
        while (pending_commands.size() != 0 || expected_results.size() != 0
               || s_axis_tvalid)
            @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------
    initial
    begin
        logic [63:0] owners[5];
        logic [63:0] masks[5];
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        m_axis_tready = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        mismatch_count = 0; result_count = 0; command_count = 0;
        idle_off = 0; hold_left = 0;
        src_gap = 0; sink_gap = 0; sent_pending = 0;
        mirror_tag = 24'd0;
        rights_mask = '1;
        wipe_table();
        repeat (2) @(posedge clk);
        #1 rst_n = 1'b1;

        // Uninitialized owner: inserts are refused; close-all on empty table.
        queue_command(CMD_INSERT, '0, 64'h1, 8'd1, '0, 1'b0, 1'b0);
        queue_command(CMD_CLOSE_ALL, '0, '0, '0, '0, 1'b0, 1'b0);
        wait_quiet();

        // Directed part: field extremes, every command, every status but no-space.
        write_register(ADDR_OWNER, 64'hffff_ffff_ffff_ffff);
        write_register(ADDR_RIGHTS, 64'h0000_0000_0000_00ff);
        queue_command(CMD_INSERT, '0, '1, 8'd15, 64'hff, 1'b1, 1'b1);
        queue_command(CMD_INSERT, '0, 64'h2, 8'd1, 64'h01, 1'b0, 1'b1);
        queue_command(CMD_INSERT, '0, 64'h3, 8'd16, 64'h01, 1'b0, 1'b0);
        queue_command(CMD_INSERT, '0, 64'h3, 8'd0, 64'h01, 1'b0, 1'b0);
        queue_command(CMD_INSERT, '0, 64'h0, 8'd2, 64'h01, 1'b0, 1'b0);
        queue_command(CMD_INSERT, '0, 64'h4, 8'd2, 64'h100, 1'b0, 1'b0);
        wait_quiet();
        queue_command(CMD_RESOLVE, issued_handles[0], '0, 8'd15, 64'hff, 1'b0, 1'b0);
        queue_command(CMD_RESOLVE, issued_handles[0], '0, 8'd3, 64'h1, 1'b0, 1'b0);
        queue_command(CMD_RESOLVE, issued_handles[1], '0, 8'd1, 64'h2, 1'b0, 1'b0);
        queue_command(CMD_RESOLVE, issued_handles[1], '0, 8'd0, 64'h1, 1'b0, 1'b0);
        queue_command(CMD_RESOLVE, '1, '0, 8'd1, '1, 1'b1, 1'b1);
        queue_command(CMD_RESOLVE, 64'h41, '0, 8'd1, 64'h0, 1'b0, 1'b0);
        queue_command(CMD_DUPLICATE, issued_handles[0], '0, 8'd0, 64'h0f, 1'b0, 1'b0);
        queue_command(CMD_DUPLICATE, issued_handles[1], '0, 8'd0, 64'h01, 1'b0, 1'b0);
        queue_command(CMD_DUPLICATE, issued_handles[0], '0, 8'd0, 64'h100, 1'b0, 1'b0);
        queue_command(CMD_CLOSE, issued_handles[0], '0, 8'd0, '0, 1'b0, 1'b0);
        queue_command(CMD_CLOSE, issued_handles[0], '0, 8'd0, '0, 1'b0, 1'b0);
        queue_command(cmd_t'(3'd7), '1, '1, 8'hff, '1, 1'b1, 1'b1);
        queue_command(CMD_CLOSE_ALL, '0, '0, 8'd0, '0, 1'b0, 1'b0);
        wait_quiet();

        // Fill every slot, then overflow, then duplicate into a full table.
        write_register(ADDR_RIGHTS, '1);
        for (int i = 0; i < NSLOT; i++)
            queue_command(CMD_INSERT, '0, rand64() | 64'h1, 8'($urandom_range(1, 15)),
                          rand64() | 64'h1, 1'b1, 1'($urandom()));
        queue_command(CMD_INSERT, '0, 64'h5, 8'd1, 64'h1, 1'b0, 1'b0);
        wait_quiet();
        queue_command(CMD_DUPLICATE, issued_handles[3], '0, 8'd0, 64'h1, 1'b0, 1'b0);
        // Receiver holds off for a long stretch while commands keep coming.
        hold_left = 150;
        for (int i = 0; i < 12; i++)
            queue_command(CMD_RESOLVE, issued_handles[i], '0, 8'd1, 64'h0, 1'b0, 1'b0);
        queue_command(CMD_CLOSE_ALL, '0, '0, 8'd0, '0, 1'b0, 1'b0);
        wait_quiet();

        // Random phases across several owner identities and rights masks.
        owners[0] = 64'h0000_0000_0000_0001;
        owners[1] = 64'h0000_0100_0000_0001;   // folds to tag 010001 hex
        owners[2] = rand64();
        owners[3] = 64'hffff_ffff_ffff_ffff;
        owners[4] = 64'h0;                     // back to uninitialized
        masks[0]  = '1;
        masks[1]  = 64'h0000_0000_0000_000f;
        masks[2]  = rand64() | 64'h1;
        masks[3]  = 64'h0;
        masks[4]  = 64'h8000_0000_0000_0001;
        for (int p = 0; p < 5; p++)
        begin
            write_register(ADDR_OWNER, owners[p]);
            write_register(ADDR_RIGHTS, masks[p]);
            for (int i = 0; i < 44; i++)
                queue_random_command();
            if (p == 4)
                idle_off = 1;
            wait_quiet();
        end

        $display("Covered %0d commands and %0d results over five owner/rights settings,",
                 command_count, result_count);
        $display("including a full table, long output stalls and stale handles.");
        if (mismatch_count == 0)
            $display("PASS generational_handle_table_top");
        else
            $display("FAIL generational_handle_table_top");
        $finish;
    end

    // Run limit: far above the slowest correct run of about 320 commands.
    initial
    begin
        #10000000;
        $display("FAIL generational_handle_table_top");
        $finish;
    end

endmodule
